@@ hw/rtl/u2a_pkg.sv @@
// Shared types, constants and helpers for the unsigned-to-ASCII digit converter.
package u2a_pkg;

	// Field widths
	localparam int VALUE_W = 32;
	localparam int BASE_W  = 8;
	localparam int CHAR_W  = 7;

	// Digit store sizing
	localparam int MAX_DIGITS = 10;
	localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

	// Command queue sizing
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Radix codes
	localparam logic [BASE_W-1:0] RADIX_DEC = 8'd10;
	localparam logic [BASE_W-1:0] RADIX_HEX = 8'd16;

	// Divide by ten: floor(n * 0xCCCCCCCD / 2^35) is exact for any 32-bit n
	localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int                 RECIP_SHIFT = 35;
	localparam int                 PROD_W      = 2 * VALUE_W;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;
	localparam logic [CHAR_W-1:0] CHAR_HEX_OFS = 7'h57; // 'a' - 10

	// What the front end decided about one incoming word
	typedef enum logic [1:0] {
		CMD_DEC  = 2'd0,
		CMD_HEX  = 2'd1,
		CMD_ZERO = 2'd2,
		CMD_BAD  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		cmd_kind_t          kind;
	} cmd_t;

	// One digit (0..15) to its lower-case ASCII character
	function automatic logic [CHAR_W-1:0] to_ascii(input logic [3:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_HEX_OFS + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/u2a_front.sv @@
// Front end: takes input words and classifies them into queue commands.
module u2a_front import u2a_pkg::*; (
	input  logic                src_valid,
	output logic                src_stall,
	input  logic [VALUE_W-1:0]  value,
	input  logic [BASE_W-1:0]   base,
	input  logic                q_full,
	output logic                q_push,
	output cmd_t                q_cmd
);

	// Hold the source off while the queue has no room
	assign src_stall = q_full;
	assign q_push    = src_valid && !q_full;

	// Classify: bad radix, zero, decimal or hex
	always_comb begin
		q_cmd.value = value;
		if (!(base inside {RADIX_DEC, RADIX_HEX})) begin
			q_cmd.kind = CMD_BAD;
		end else if (value == '0) begin
			q_cmd.kind = CMD_ZERO;
		end else if (base == RADIX_HEX) begin
			q_cmd.kind = CMD_HEX;
		end else begin
			q_cmd.kind = CMD_DEC;
		end
	end

endmodule

@@ hw/rtl/u2a_queue.sv @@
// Short command queue between the front end and the conversion engine.
module u2a_queue import u2a_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cmd_t  push_cmd,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output cmd_t  head
);

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/u2a_back.sv @@
// Conversion engine: peels digits off lowest first, then sends them out in reverse.
module u2a_back import u2a_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  cmd_t               q_head,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last,
	output logic               bad_base
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIG  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                state_q;
	logic [VALUE_W-1:0]    rem_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  hex_q;
	logic                  err_q;
	logic [DIG_CNT_W-1:0]  cnt_q;
	logic [DIG_IDX_W-1:0]  idx_q;
	logic [CHAR_W-1:0]     store_q [MAX_DIGITS];

	logic                  res_valid_q;
	logic [CHAR_W-1:0]     digit_char_q;
	logic                  last_q;
	logic                  bad_q;

	logic [VALUE_W-1:0]    quot;
	logic [VALUE_W-1:0]    quot_times;
	logic [3:0]            rem_digit;
	logic [DIG_CNT_W-1:0]  cnt_next;
	logic                  dig_done;
	logic                  emit_load;

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	// One digit step: quotient by shift (hex) or reciprocal product (decimal)
	always_comb begin
		if (hex_q) begin
			quot       = rem_q >> 4;
			quot_times = quot << 4;
		end else begin
			quot       = VALUE_W'(prod_q[PROD_W-1:RECIP_SHIFT]);
			quot_times = (quot << 3) + (quot << 1);
		end
		rem_digit = 4'(rem_q - quot_times);
		cnt_next  = cnt_q + 1'b1;
		dig_done  = (quot == '0) || (cnt_next == DIG_CNT_W'(MAX_DIGITS));
	end

	// Output register takes a new character when empty or being drained
	assign emit_load = (state_q == ST_EMIT) && (!res_valid_q || !res_stall);

	// Digit store
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_pop && q_head.kind == CMD_ZERO) begin
			store_q[0] <= CHAR_ZERO;
		end else if (state_q == ST_DIG) begin
			store_q[cnt_q[DIG_IDX_W-1:0]] <= to_ascii(rem_digit);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q <= q_head.value;
				hex_q <= (q_head.kind == CMD_HEX);
				err_q <= (q_head.kind == CMD_BAD);
			end
			ST_MUL: begin
				prod_q <= PROD_W'(rem_q) * PROD_W'(RECIP_10);
			end
			ST_DIG: begin
				rem_q <= quot;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_head.kind == CMD_BAD || q_head.kind == CMD_ZERO) begin
							cnt_q   <= DIG_CNT_W'(1);
							idx_q   <= '0;
							state_q <= ST_EMIT;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_DIG;
				end
				ST_DIG: begin
					cnt_q <= cnt_next;
					if (dig_done) begin
						idx_q   <= cnt_q[DIG_IDX_W-1:0];
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output word payload, most significant digit first
	always_ff @(posedge clk) begin
		if (emit_load) begin
			digit_char_q <= err_q ? CHAR_NONE : store_q[idx_q];
			last_q       <= (idx_q == '0);
			bad_q        <= err_q;
		end
	end

	assign res_valid  = res_valid_q;
	assign digit_char = digit_char_q;
	assign last       = last_q;
	assign bad_base   = bad_q;

	// An error word is always a lone, blank, final word
	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && bad_q |-> last_q && (digit_char_q == CHAR_NONE))
		else $error("bad-base word is not a single blank final word");

	// Digit count never runs past the store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DIG_CNT_W'(MAX_DIGITS))
		else $error("digit count exceeds store size");

	// Emission index stays inside the digits found
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (DIG_CNT_W'(idx_q) < cnt_q))
		else $error("emit index outside digit count");

	// A digit step always follows its multiply
	a_mul_dig: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_DIG))
		else $error("multiply not followed by digit step");

endmodule

@@ hw/rtl/unsigned_to_ascii_digits.sv @@
// Top level of the unsigned-to-ASCII digit converter.
// Converts a 32-bit unsigned value to lower-case ASCII digits in base 10 or 16,
// most significant first, no leading zeros, with last set on the final word; a
// zero value gives the single word '0', and any other base gives one word with
// bad_base and last set and digit_char 0. Input words land in a two-deep command
// queue, so the source can run ahead by two words. The engine picks up a command,
// then works out each digit with a multiply by the reciprocal of ten (used only
// for decimal) and then the quotient and remainder step, then sends the characters
// out one at a time through the output register, holding while the sink stalls.
// A zero value or a bad base skips the digit steps.
module unsigned_to_ascii_digits import u2a_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  logic [VALUE_W-1:0] value,
	input  logic [BASE_W-1:0]  base,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last,
	output logic               bad_base
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	cmd_t q_cmd;
	cmd_t q_head;

	u2a_front u_front (
		.src_valid (src_valid),
		.src_stall (src_stall),
		.value     (value),
		.base      (base),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	u2a_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	u2a_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.digit_char (digit_char),
		.last       (last),
		.bad_base   (bad_base)
	);

endmodule

@@ tb/tb.sv @@
// Testbench for the unsigned-to-ASCII digit converter: directed and random words, self-checked.
`timescale 1ns / 100ps

module tb;
	import u2a_pkg::*;

	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
	localparam int unsigned       HOLD_CYCLES = 400;

	// One expected output character
	typedef struct packed {
		logic [CHAR_W-1:0] digit;
		logic              fin;
		logic              err;
	} char_word_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_stall;
	logic [VALUE_W-1:0] value = '0;
	logic [BASE_W-1:0]  base = RADIX_DEC;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic [CHAR_W-1:0]  digit_char;
	logic               last;
	logic               bad_base;

	// Predictor state and expected characters
	char_word_t         expected_chars[$];
	logic [VALUE_W-1:0] leftover_quot = '0;
	int unsigned        digits_found = 0;
	int unsigned        fail_count = 0;

	// Sender and receiver pacing
	bit                 gaps_on = 1'b0;
	int unsigned        burst_left = 0;
	stall_mode_t        stall_mode = STALL_NONE;
	int unsigned        hold_asks = 0;
	int unsigned        hold_seen = 0;
	int unsigned        hold_left = 0;
	int unsigned        stall_run = 0;
	logic               stall_on = 1'b0;

	unsigned_to_ascii_digits dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.value      (value),
		.base       (base),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.digit_char (digit_char),
		.last       (last),
		.bad_base   (bad_base)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Work out the characters one accepted word should produce
	task automatic predict_digits(input logic [VALUE_W-1:0] v, input logic [BASE_W-1:0] b);
		logic [VALUE_W-1:0] n;
		logic [VALUE_W-1:0] radix;
		logic [VALUE_W-1:0] d;
		logic [CHAR_W-1:0]  found[MAX_DIGITS];
		int unsigned        cnt;
		char_word_t         w;
		if (b != RADIX_DEC && b != RADIX_HEX) begin
			w.digit = CHAR_NONE;
			w.fin = 1'b1;
			w.err = 1'b1;
			expected_chars.push_back(w);
			return;
		end
		radix = VALUE_W'(b);
		n = v;
		cnt = 0;
		if (n == '0) begin
			found[0] = CHAR_ZERO;
			cnt = 1;
		end
		// lowest digit first
		while (n != '0 && cnt < MAX_DIGITS) begin
			d = n % radix;
			if (d < 10)
				found[cnt] = CHAR_ZERO + CHAR_W'(d);
			else
				found[cnt] = ASCII_LOWER_A + CHAR_W'(d - 10);
			n = n / radix;
			cnt++;
		end
		leftover_quot = n;
		digits_found = cnt;
		// emitted most significant first
		for (int k = 0; k < cnt; k++) begin
			w.digit = found[cnt - 1 - k];
			w.fin = (k == cnt - 1);
			w.err = 1'b0;
			expected_chars.push_back(w);
		end
	endtask

	// Prediction on accepted input words, check on accepted output words
	always @(posedge clk) begin
		char_word_t w;
		if (res_valid && !res_stall) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected word: digit_char %0h last %0b bad_base %0b",
					digit_char, last, bad_base);
				fail_count++;
			end else begin
				w = expected_chars.pop_front();
				if (digit_char !== w.digit) begin
					$error("digit_char mismatch: expected %0h, got %0h", w.digit, digit_char);
					fail_count++;
				end
				if (last !== w.fin) begin
					$error("last mismatch: expected %0b, got %0b", w.fin, last);
					fail_count++;
				end
				if (bad_base !== w.err) begin
					$error("bad_base mismatch: expected %0b, got %0b", w.err, bad_base);
					fail_count++;
				end
			end
		end
		if (arst_n && src_valid && !src_stall)
			predict_digits(value, base);
	end

	// Receiver stall pattern, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			if (stall_run == 0) begin
				stall_run = $urandom_range(1, 6);
				case (stall_mode)
					STALL_NONE: begin
						stall_on = 1'b0;
					end
					STALL_LIGHT: begin
						stall_on = ($urandom_range(0, 99) < 25);
					end
					default: begin
						stall_on = ($urandom_range(0, 99) < 75);
					end
				endcase
			end
			stall_run--;
			res_stall <= stall_on;
		end
	end

	// Offer one word and hold it until accepted; bursts with random gaps
	task automatic send_word(input logic [VALUE_W-1:0] v, input logic [BASE_W-1:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			if (gaps_on) begin
				gap = $urandom_range(1, 8);
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
				: $urandom_range(1, 5);
		end
		src_valid <= 1'b1;
		value <= v;
		base <= b;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		burst_left--;
	endtask

	// Zero, ones, boundaries of digit counts, and the largest values
	task automatic test_extremes();
		stall_mode = STALL_NONE;
		gaps_on = 1'b0;
		send_word(32'd0, RADIX_DEC);
		send_word(32'd0, RADIX_HEX);
		send_word(32'd1, RADIX_DEC);
		send_word(32'd9, RADIX_DEC);
		send_word(32'd10, RADIX_DEC);
		send_word(32'd15, RADIX_HEX);
		send_word(32'd16, RADIX_HEX);
		send_word(32'd999_999_999, RADIX_DEC);
		send_word(32'd1_000_000_000, RADIX_DEC);
		send_word(32'hFFFF_FFFF, RADIX_DEC);
		send_word(32'hFFFF_FFFF, RADIX_HEX);
		send_word(32'h1000_0000, RADIX_HEX);
		send_word(32'hABCD_EF01, RADIX_HEX);
		send_word(32'h8000_0000, RADIX_DEC);
	endtask

	// Bases other than ten and sixteen, every base bit exercised
	task automatic test_bad_base();
		stall_mode = STALL_LIGHT;
		gaps_on = 1'b1;
		send_word($urandom, 8'd0);
		send_word(32'd0, 8'hFF);
		send_word($urandom, 8'd11);
		send_word($urandom, 8'd15);
		send_word($urandom, 8'd17);
		send_word(32'hFFFF_FFFF, 8'd2);
		send_word($urandom, 8'd8);
		send_word($urandom, 8'h40);
		send_word($urandom, 8'h80);
		send_word(32'd123, 8'h1A);
		// a good conversion right after an error word
		send_word(32'd123, RADIX_DEC);
	endtask

	// Mostly valid conversions of varied length, some bad bases
	task automatic test_random_mix();
		logic [VALUE_W-1:0] v;
		logic [BASE_W-1:0]  b;
		logic [VALUE_W-1:0] p;
		int unsigned        r;
		gaps_on = 1'b1;
		for (int i = 0; i < 240; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: stall_mode = STALL_NONE;
					1: stall_mode = STALL_LIGHT;
					default: stall_mode = STALL_HEAVY;
				endcase
				gaps_on = ($urandom_range(0, 3) != 0);
			end
			r = $urandom_range(0, 99);
			if (r < 45)
				b = RADIX_DEC;
			else if (r < 90)
				b = RADIX_HEX;
			else
				b = BASE_W'($urandom_range(0, 255));
			case ($urandom_range(0, 3))
				0: v = $urandom;
				1: v = $urandom >> $urandom_range(0, 31);
				2: v = $urandom_range(0, 20);
				default: begin
					// around a power of ten
					p = 1;
					repeat ($urandom_range(0, 9)) p = p * 10;
					v = p - $urandom_range(0, 1);
				end
			endcase
			send_word(v, b);
		end
	endtask

	// Receiver holds off while the sender keeps offering words
	task automatic test_backpressure();
		stall_mode = STALL_NONE;
		gaps_on = 1'b0;
		hold_asks++;
		for (int i = 0; i < 16; i++)
			send_word($urandom, ($urandom_range(0, 1) != 0) ? RADIX_DEC : RADIX_HEX);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_bad_base();
		test_random_mix();
		test_backpressure();
		src_valid <= 1'b0;
		stall_mode = STALL_LIGHT;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0 && expected_chars.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
